// ----- rtl/core/scp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial command parser package
// Phase and action code types, character constants and the mnemonic table.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ArgW  = 32;
  localparam int unsigned MnemW = 3 * ByteW;

  localparam logic [ByteW-1:0] TermReset = 8'd59;

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2b;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  // Largest accumulator value that can still take a digit, and its last digit.
  localparam logic [ArgW-1:0] AccLimit   = 32'd429496729;
  localparam logic [3:0]      DigitLimit = 4'd5;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_LETTER,
    PH_SPACE,
    PH_DIGITS,
    PH_IGNORE
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_SEL  = 3'd1,
    ACT_CLO  = 3'd2,
    ACT_PMA  = 3'd3,
    ACT_PMB  = 3'd4,
    ACT_PUL  = 3'd5
  } action_t;

  function automatic logic [MnemW-1:0] pack3(input logic [ByteW-1:0] a,
                                             input logic [ByteW-1:0] b,
                                             input logic [ByteW-1:0] c);
    return {c, b, a};
  endfunction

  function automatic action_t lookup_action(input logic [MnemW-1:0] m);
    action_t act;
    act = ACT_NONE;
    if (m == pack3("s", "e", "l")) act = ACT_SEL;
    else if (m == pack3("c", "l", "o")) act = ACT_CLO;
    else if (m == pack3("p", "m", "v")) act = ACT_PMA;
    else if (m == pack3("p", "m", "a")) act = ACT_PMA;
    else if (m == pack3("p", "m", "b")) act = ACT_PMB;
    else if (m == pack3("p", "u", "l")) act = ACT_PUL;
    return act;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/serial_command_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial command parser
// Parses a stream of received bytes into one action code and argument per line.
// ----------------------------------------------------------------------------
// Bytes enter on the in_ channel (valid/ready), one item per byte. Leading
// spaces are skipped, three letters form the command mnemonic, and for
// commands that take an argument a signed decimal number follows. A zero byte
// or the terminator byte (cfg_wr_data written with cfg_wr_en, 59 after reset)
// closes the line and produces one item on the out_ channel.
// Throughput is one byte per cycle while in_ready is high: the parse state and
// the multiply-by-ten accumulator are updated in the cycle a byte is accepted.
// A result appears in the output register in the cycle after its terminator
// byte is accepted. The output register holds its item while out_ready is low;
// in_ready stays high as long as the output register is empty or being emptied,
// so a stall on the out_ channel only blocks input when a finished result
// still waits. Synchronous reset returns the parser to the start of a line,
// empties the output register and sets the terminator back to 59.
// ----------------------------------------------------------------------------
module serial_command_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [scp_pkg::ByteW-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [scp_pkg::ByteW-1:0] in_rx_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [2:0]                     out_action_code,
  output logic [scp_pkg::ArgW-1:0]       out_argument
);
  import scp_pkg::*;

  logic [ByteW-1:0] term_r;
  phase_t           phase_r, phase_nxt;
  logic [1:0]       letter_cnt_r, letter_cnt_nxt;
  logic [MnemW-1:0] mnem_r, mnem_nxt;
  logic [ArgW-1:0]  acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic             minus_r, minus_nxt;
  logic             mism_r, mism_nxt;

  logic             out_valid_r, out_valid_nxt;
  action_t          out_act_r, out_act_nxt;
  logic [ArgW-1:0]  out_arg_r, out_arg_nxt;

  logic             in_acc;
  logic             is_term, is_ws, is_digit, digit_fits;
  logic [3:0]       digit;
  logic [ArgW-1:0]  acc_x10;
  action_t          act_new, act_line;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign is_term  = (in_rx_byte == '0) || (in_rx_byte == term_r);
  assign is_ws    = (in_rx_byte == ChSpace) ||
                    ((in_rx_byte >= ChTab) && (in_rx_byte <= ChCr));
  assign is_digit = (in_rx_byte >= ChZero) && (in_rx_byte <= ChNine);
  assign digit    = in_rx_byte[3:0];
  assign digit_fits = (acc_r < AccLimit) || ((acc_r == AccLimit) && (digit <= DigitLimit));
  assign acc_x10  = {acc_r[ArgW-4:0], 3'b000} + {acc_r[ArgW-2:0], 1'b0};

  assign act_new  = lookup_action({in_rx_byte, mnem_r[2*ByteW-1:0]});
  assign act_line = (letter_cnt_r == 2'd3 && !mism_r) ? lookup_action(mnem_r) : ACT_NONE;

  // Phase sequencing.
  always_comb begin
    phase_nxt = phase_r;
    if (is_term) begin
      phase_nxt = PH_LEAD;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (in_rx_byte != ChSpace) phase_nxt = PH_LETTER;
        end
        PH_LETTER: begin
          if (letter_cnt_r == 2'd2) begin
            if (act_new == ACT_NONE || act_new == ACT_CLO) phase_nxt = PH_IGNORE;
            else phase_nxt = PH_SPACE;
          end
        end
        PH_SPACE: begin
          if (!is_ws) begin
            if (in_rx_byte == ChPlus || in_rx_byte == ChMinus || is_digit) begin
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_IGNORE;
            end
          end
        end
        PH_DIGITS: begin
          if (!is_digit) phase_nxt = PH_IGNORE;
        end
        default: phase_nxt = PH_IGNORE;
      endcase
    end
  end

  // Line state and result.
  always_comb begin
    letter_cnt_nxt = letter_cnt_r;
    mnem_nxt       = mnem_r;
    acc_nxt        = acc_r;
    ovf_nxt        = ovf_r;
    minus_nxt      = minus_r;
    mism_nxt       = mism_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_act_nxt    = out_act_r;
    out_arg_nxt    = out_arg_r;

    case (phase_r)
      PH_LEAD: begin
        mnem_nxt = {{(MnemW-ByteW){1'b0}}, in_rx_byte};
      end
      PH_LETTER: begin
        if (letter_cnt_r == 2'd1) mnem_nxt = {mnem_r[MnemW-1:2*ByteW], in_rx_byte, mnem_r[ByteW-1:0]};
        else mnem_nxt = {in_rx_byte, mnem_r[2*ByteW-1:0]};
      end
      default: ;
    endcase

    if (is_term) begin
      out_valid_nxt  = 1'b1;
      out_act_nxt    = act_line;
      if (act_line == ACT_NONE || act_line == ACT_CLO) out_arg_nxt = '0;
      else if (ovf_r) out_arg_nxt = '1;
      else if (minus_r) out_arg_nxt = '0 - acc_r;
      else out_arg_nxt = acc_r;
      letter_cnt_nxt = '0;
      mnem_nxt       = '0;
      acc_nxt        = '0;
      ovf_nxt        = 1'b0;
      minus_nxt      = 1'b0;
      mism_nxt       = 1'b0;
    end else begin
      case (phase_r)
        PH_LEAD: begin
          if (in_rx_byte != ChSpace) letter_cnt_nxt = 2'd1;
          else mnem_nxt = mnem_r;
        end
        PH_LETTER: begin
          letter_cnt_nxt = letter_cnt_r + 2'd1;
          if (letter_cnt_r == 2'd2 && act_new == ACT_NONE) mism_nxt = 1'b1;
        end
        PH_SPACE, PH_DIGITS: begin
          if (phase_r == PH_SPACE && !is_ws && in_rx_byte == ChMinus) minus_nxt = 1'b1;
          if (is_digit && !ovf_r) begin
            if (digit_fits) acc_nxt = acc_x10 + {{(ArgW-4){1'b0}}, digit};
            else ovf_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r       <= TermReset;
      phase_r      <= PH_LEAD;
      letter_cnt_r <= '0;
      mnem_r       <= '0;
      acc_r        <= '0;
      ovf_r        <= 1'b0;
      minus_r      <= 1'b0;
      mism_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) term_r <= cfg_wr_data;
      if (in_acc) begin
        phase_r      <= phase_nxt;
        letter_cnt_r <= letter_cnt_nxt;
        mnem_r       <= mnem_nxt;
        acc_r        <= acc_nxt;
        ovf_r        <= ovf_nxt;
        minus_r      <= minus_nxt;
        mism_r       <= mism_nxt;
        out_valid_r  <= out_valid_nxt;
      end else begin
        out_valid_r  <= out_valid_r && !out_ready;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_term) begin
      out_act_r <= out_act_nxt;
      out_arg_r <= out_arg_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action_code = out_act_r;
  assign out_argument    = out_arg_r;

  a_mism_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    mism_r |-> phase_r == PH_IGNORE)
    else $error("mismatch flag set outside the ignore phase");

  a_num_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r || minus_r) |-> (phase_r == PH_DIGITS || phase_r == PH_IGNORE))
    else $error("number flags set before the number phase");

  a_lead_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEAD) |-> (letter_cnt_r == 2'd0 && acc_r == '0))
    else $error("line state not cleared at the start of a line");

  a_no_arg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_act_r == ACT_NONE || out_act_r == ACT_CLO)) |-> out_arg_r == '0)
    else $error("argument given for a command without one");

  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_term) |=> out_valid_r && phase_r == PH_LEAD)
    else $error("terminator did not produce a result");

endmodule
`default_nettype wire
